// ----- rtl/nec_ir_pulse_decoder_assert.svh -----
// ---------------------------------------------------------------------------
// NEC IR pulse decoder assertion macros
// Shared concurrent assertion forms for the decoder's checker.
// ---------------------------------------------------------------------------
`ifndef NEC_IR_PULSE_DECODER_ASSERT_SVH
`define NEC_IR_PULSE_DECODER_ASSERT_SVH

// property checked on every clock edge outside reset
`define NIRPD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("nirpd assertion failed");

// property checked on every clock edge, reset included
`define NIRPD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("nirpd assertion failed");

`endif

// ----- rtl/nirpd_pkg.sv -----
// ---------------------------------------------------------------------------
// NEC IR pulse decoder package
// Transaction types, decoder states, status codes and timing windows.
// ---------------------------------------------------------------------------
package nirpd_pkg;

   typedef struct packed {
      logic        phase_is_space;
      logic [15:0] duration_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] address_byte;
      logic [7:0] address_inverse;
      logic [7:0] command_byte;
      logic [7:0] command_inverse;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD_SPACE,
      PH_REP_MARK,
      PH_BIT_MARK,
      PH_BIT_SPACE
   } phase_type;

   // window hits for the current phase duration
   typedef struct packed {
      logic lead_mark;
      logic lead_space;
      logic rep_space;
      logic short_win;
      logic long_win;
   } window_type;

   localparam logic [1:0] ST_FRAME   = 2'd0;
   localparam logic [1:0] ST_REPEAT  = 2'd1;
   localparam logic [1:0] ST_BAD_BIT = 2'd2;

   localparam logic [5:0] FRAME_BITS = 6'd32;

   // exclusive bounds, in timer ticks
   localparam logic [15:0] LEAD_MARK_LO  = 16'd2700;
   localparam logic [15:0] LEAD_MARK_HI  = 16'd2850;
   localparam logic [15:0] LEAD_SPACE_LO = 16'd1350;
   localparam logic [15:0] LEAD_SPACE_HI = 16'd1450;
   localparam logic [15:0] REP_SPACE_LO  = 16'd625;
   localparam logic [15:0] REP_SPACE_HI  = 16'd775;
   localparam logic [15:0] SHORT_LO      = 16'd160;
   localparam logic [15:0] SHORT_HI      = 16'd190;
   localparam logic [15:0] LONG_LO       = 16'd490;
   localparam logic [15:0] LONG_HI       = 16'd560;

   localparam logic [31:0] REPEAT_WORD = 32'hFFFF_FFFF;

endpackage

// ----- rtl/nec_ir_pulse_decoder.sv -----
// ---------------------------------------------------------------------------
// NEC IR pulse decoder
// Turns measured mark/space phases into NEC frames, repeats and bit errors.
// ---------------------------------------------------------------------------
// Takes one phase transaction per clock cycle while not stalled. Each phase
// lands in an input register and is decoded from there by a single-pass
// state machine that writes the result register, once no blocked result
// holds it back. The input stalls only while a result is held in the
// output register and the receiver stalls; an empty input register still
// takes one more phase during that time. Phases that finish nothing (leader,
// mark halves of bits, ignored idle phases) produce no result transaction.
module nec_ir_pulse_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  nirpd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nirpd_pkg::rsp_type rsp_data
);
   import nirpd_pkg::*;

   logic       in_valid_ff;
   req_type    in_data_ff;
   phase_type  phase_ff, phase_in;
   logic [5:0] count_ff, count_in;
   logic [31:0] shift_ff, shift_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;

   window_type windows;
   logic       proc;
   logic       space;
   logic       emit;
   logic [1:0] emit_status;
   logic [31:0] emit_word;
   logic [5:0] count_next;
   logic [31:0] shift_next;

   nirpd_classify u_classify (
      .duration_ticks (in_data_ff.duration_ticks),
      .windows        (windows)
   );

   assign proc      = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign space     = in_data_ff.phase_is_space;

   assign count_next = count_ff + 6'd1;
   assign shift_next = {shift_ff[30:0], windows.long_win};

   // next state
   always_comb begin
      phase_in = PH_IDLE;
      count_in = '0;
      shift_in = '0;
      case (phase_ff)
         PH_LEAD_SPACE: begin
            if (space && windows.lead_space) begin
               phase_in = PH_BIT_MARK;
            end else if (space && windows.rep_space) begin
               phase_in = PH_REP_MARK;
            end
         end
         PH_REP_MARK: begin
            phase_in = PH_IDLE;
         end
         PH_BIT_MARK: begin
            if (!space && windows.short_win) begin
               phase_in = PH_BIT_SPACE;
               count_in = count_ff;
               shift_in = shift_ff;
            end
         end
         PH_BIT_SPACE: begin
            if (space && (windows.short_win || windows.long_win) &&
                (count_next < FRAME_BITS)) begin
               phase_in = PH_BIT_MARK;
               count_in = count_next;
               shift_in = shift_next;
            end
         end
         default: begin
            if (!space && windows.lead_mark) begin
               phase_in = PH_LEAD_SPACE;
            end
         end
      endcase
   end

   // result decision
   always_comb begin
      emit        = 1'b0;
      emit_status = ST_FRAME;
      emit_word   = '0;
      case (phase_ff)
         PH_REP_MARK: begin
            if (!space && windows.short_win) begin
               emit        = 1'b1;
               emit_status = ST_REPEAT;
               emit_word   = REPEAT_WORD;
            end
         end
         PH_BIT_MARK: begin
            if (space || !windows.short_win) begin
               emit        = 1'b1;
               emit_status = ST_BAD_BIT;
            end
         end
         PH_BIT_SPACE: begin
            if (!(space && (windows.short_win || windows.long_win))) begin
               emit        = 1'b1;
               emit_status = ST_BAD_BIT;
            end else if (count_next >= FRAME_BITS) begin
               emit        = 1'b1;
               emit_status = ST_FRAME;
               emit_word   = shift_next;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // input register: take a new phase whenever not stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         shift_ff <= '0;
      end else if (proc) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && emit) begin
         rsp_data_ff.status          <= emit_status;
         rsp_data_ff.address_byte    <= emit_word[31:24];
         rsp_data_ff.address_inverse <= emit_word[23:16];
         rsp_data_ff.command_byte    <= emit_word[15:8];
         rsp_data_ff.command_inverse <= emit_word[7:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/nirpd_classify.sv -----
// ---------------------------------------------------------------------------
// NEC IR phase duration classifier
// Compares one phase duration against every NEC timing window.
// ---------------------------------------------------------------------------
module nirpd_classify (
   input  logic [15:0]          duration_ticks,
   output nirpd_pkg::window_type windows
);
   import nirpd_pkg::*;

   always_comb begin
      windows.lead_mark  = (duration_ticks > LEAD_MARK_LO)  && (duration_ticks < LEAD_MARK_HI);
      windows.lead_space = (duration_ticks > LEAD_SPACE_LO) && (duration_ticks < LEAD_SPACE_HI);
      windows.rep_space  = (duration_ticks > REP_SPACE_LO)  && (duration_ticks < REP_SPACE_HI);
      windows.short_win  = (duration_ticks > SHORT_LO)      && (duration_ticks < SHORT_HI);
      windows.long_win   = (duration_ticks > LONG_LO)       && (duration_ticks < LONG_HI);
   end

endmodule

// ----- rtl/nirpd_checker.sv -----
// ---------------------------------------------------------------------------
// NEC IR pulse decoder checker
// Port-level properties of the decoder, bound to its top level.
// ---------------------------------------------------------------------------
`include "nec_ir_pulse_decoder_assert.svh"

module nirpd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input nirpd_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input nirpd_pkg::rsp_type rsp_data
);
   import nirpd_pkg::*;

   logic [31:0] rsp_word;
   logic        rsp_blocked;
   logic        req_blocked;
   logic        payload_ok;

   assign rsp_word = {rsp_data.address_byte, rsp_data.address_inverse,
                      rsp_data.command_byte, rsp_data.command_inverse};
   assign rsp_blocked = rsp_valid && rsp_stall;
   assign req_blocked = req_valid && req_stall;
   assign payload_ok  = (rsp_data.status == ST_FRAME) ||
                        (rsp_data.status == ST_REPEAT && rsp_word == REPEAT_WORD) ||
                        (rsp_data.status == ST_BAD_BIT && rsp_word == '0);

   // a stalled result transaction holds
   `NIRPD_ASSERT(a_rsp_hold, clock, reset, rsp_blocked |=> rsp_valid && $stable(rsp_data))

   // a stalled input transaction holds
   `NIRPD_ASSERT(a_req_hold, clock, reset, req_blocked |=> req_valid && $stable(req_data))

   // input backs up only behind a blocked result
   `NIRPD_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)

   // repeats carry all ones, errors all zeros, no other status codes
   `NIRPD_ASSERT(a_rsp_payload, clock, reset, rsp_valid |-> payload_ok)

   // no result right after reset
   `NIRPD_ASSERT_ALWAYS(a_reset_empty, clock, !reset && $past(reset) |-> !rsp_valid && !req_stall)

endmodule

bind nec_ir_pulse_decoder nirpd_checker u_nirpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// NEC IR pulse decoder testbench
// Feeds mark/space phases (directed edge cases, then random frames, repeats,
// broken bursts and noise) under several sender/receiver idling mixes, and
// checks every result transaction against an in-bench decoder model.
// ---------------------------------------------------------------------------
module tb_top;
   import nirpd_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 420;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic        is_space;
      logic [15:0] dur;
      logic [15:0] lo;
      logic [15:0] hi;
   } ir_phase_type;

   // expected decoder behavior plus the queue of results still owed
   class ir_frame_scoreboard;
      phase_type   decode_st;
      logic [5:0]  bits_seen;
      logic [31:0] frame_word;
      rsp_type     pending[$];
      int          errors;
      int          results;

      function new();
         errors = 0;
         results = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         decode_st = PH_IDLE;
         bits_seen = '0;
         frame_word = '0;
      endfunction

      function bit in_win(logic [15:0] d, logic [15:0] lo, logic [15:0] hi);
         return d > lo && d < hi;
      endfunction

      function void finish_result(logic [1:0] st, logic [31:0] w);
         pending.push_back({st, w});
         results++;
         clear_frame();
      endfunction

      function void note_phase(logic is_space, logic [15:0] d);
         case (decode_st)
            PH_LEAD_SPACE: begin
               if (is_space && in_win(d, LEAD_SPACE_LO, LEAD_SPACE_HI)) begin
                  decode_st = PH_BIT_MARK;
                  bits_seen = '0;
                  frame_word = '0;
               end else if (is_space && in_win(d, REP_SPACE_LO, REP_SPACE_HI))
                  decode_st = PH_REP_MARK;
               else
                  clear_frame();
            end
            PH_REP_MARK: begin
               if (!is_space && in_win(d, SHORT_LO, SHORT_HI))
                  finish_result(ST_REPEAT, REPEAT_WORD);
               else
                  clear_frame();
            end
            PH_BIT_MARK: begin
               if (!is_space && in_win(d, SHORT_LO, SHORT_HI))
                  decode_st = PH_BIT_SPACE;
               else
                  finish_result(ST_BAD_BIT, 32'h0);
            end
            PH_BIT_SPACE: begin
               if (is_space && in_win(d, SHORT_LO, SHORT_HI))
                  frame_word = {frame_word[30:0], 1'b0};
               else if (is_space && in_win(d, LONG_LO, LONG_HI))
                  frame_word = {frame_word[30:0], 1'b1};
               else begin
                  finish_result(ST_BAD_BIT, 32'h0);
                  return;
               end
               bits_seen = bits_seen + 6'd1;
               if (bits_seen >= FRAME_BITS)
                  finish_result(ST_FRAME, frame_word);
               else
                  decode_st = PH_BIT_MARK;
            end
            default: begin
               if (!is_space && in_win(d, LEAD_MARK_LO, LEAD_MARK_HI)) begin
                  decode_st = PH_LEAD_SPACE;
                  bits_seen = '0;
                  frame_word = '0;
               end else
                  clear_frame();
            end
         endcase
      endfunction

      function void report_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, name, exp_v, act_v);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %0h", $time, got);
            return;
         end
         want = pending.pop_front();
         report_field("status", {6'd0, want.status}, {6'd0, got.status});
         report_field("address_byte", want.address_byte, got.address_byte);
         report_field("address_inverse", want.address_inverse, got.address_inverse);
         report_field("command_byte", want.command_byte, got.command_byte);
         report_field("command_inverse", want.command_inverse, got.command_inverse);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   ir_frame_scoreboard sb = new();

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_started = 0;
   int hold_left = 0;
   int useful_items = 0;
   int cycles = 0;
   ir_phase_type burst_q[$];

   nec_ir_pulse_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_started != hold_requests) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         holds_started <= holds_started + 1;
      end else
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // outputs only move at the rising edge, so sample at the falling edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic send_phase(input logic is_space, input logic [15:0] d);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {is_space, d};
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      sb.note_phase(is_space, d);
   endtask

   task automatic add_phase(input logic is_space, input logic [15:0] lo,
                            input logic [15:0] hi);
      ir_phase_type ph;
      ph.is_space = is_space;
      ph.lo = lo;
      ph.hi = hi;
      ph.dur = 16'($urandom_range(int'(hi) - 1, int'(lo) + 1));
      burst_q.push_back(ph);
   endtask

   task automatic add_bit(input logic one);
      add_phase(1'b0, SHORT_LO, SHORT_HI);
      if (one)
         add_phase(1'b1, LONG_LO, LONG_HI);
      else
         add_phase(1'b1, SHORT_LO, SHORT_HI);
   endtask

   // build one burst of phases, maybe damage one phase, then send it
   task automatic send_burst();
      int          pick;
      int          idx;
      int          nbits;
      logic [31:0] w;
      logic [7:0]  a;
      logic [7:0]  c;
      bit          noise;
      burst_q.delete();
      noise = 1'b0;
      pick = $urandom_range(99);
      if (pick < 45) begin
         a = 8'($urandom);
         c = 8'($urandom);
         case ($urandom_range(7))
            0: w = 32'h0;
            1: w = 32'hFFFF_FFFF;
            2, 3, 4: w = {a, ~a, c, ~c};
            default: w = $urandom;
         endcase
         add_phase(1'b0, LEAD_MARK_LO, LEAD_MARK_HI);
         add_phase(1'b1, LEAD_SPACE_LO, LEAD_SPACE_HI);
         for (int i = 31; i >= 0; i--)
            add_bit(w[i]);
         add_phase(1'b0, SHORT_LO, SHORT_HI);
      end else if (pick < 65) begin
         add_phase(1'b0, LEAD_MARK_LO, LEAD_MARK_HI);
         add_phase(1'b1, REP_SPACE_LO, REP_SPACE_HI);
         add_phase(1'b0, SHORT_LO, SHORT_HI);
      end else if (pick < 85) begin
         // leader and a few good bits, then a broken bit half
         nbits = $urandom_range(5);
         add_phase(1'b0, LEAD_MARK_LO, LEAD_MARK_HI);
         add_phase(1'b1, LEAD_SPACE_LO, LEAD_SPACE_HI);
         for (int i = 0; i < nbits; i++)
            add_bit(1'($urandom_range(1)));
         if ($urandom_range(1))
            add_phase(1'b0, SHORT_LO, SHORT_HI);
         add_phase(1'b1, SHORT_LO, SHORT_HI);
         burst_q[burst_q.size() - 1].dur = 16'($urandom);
      end else begin
         noise = 1'b1;
         for (int i = $urandom_range(4, 1); i > 0; i--)
            add_phase(1'($urandom_range(1)), 16'd0, 16'd2);
         foreach (burst_q[i])
            burst_q[i].dur = 16'($urandom);
      end
      if (!noise && $urandom_range(3) == 0) begin
         idx = $urandom_range(burst_q.size() - 1);
         case ($urandom_range(3))
            0: burst_q[idx].is_space = ~burst_q[idx].is_space;
            1: burst_q[idx].dur = 16'($urandom);
            2: burst_q[idx].dur = burst_q[idx].lo;
            default: burst_q[idx].dur = burst_q[idx].hi;
         endcase
      end
      foreach (burst_q[i]) begin
         send_phase(burst_q[i].is_space, burst_q[i].dur);
         if (!noise)
            useful_items++;
      end
   endtask

   task automatic run_phase(input int sender_pct, input int stall_pct, input int n_items);
      int start;
      start = useful_items;
      send_idle_pct = sender_pct;
      rsp_stall_pct = stall_pct;
      while (useful_items - start < n_items)
         send_burst();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle: spaces, short marks and marks on the leader bounds are dropped
      send_phase(1'b1, 16'hFFFF);
      send_phase(1'b0, 16'h0000);
      send_phase(1'b0, LEAD_MARK_LO);
      send_phase(1'b0, LEAD_MARK_HI);
      // leader space on its lower bound: back to idle quietly
      send_phase(1'b0, LEAD_MARK_LO + 16'd1);
      send_phase(1'b1, LEAD_SPACE_LO);
      // repeat code at the window edges
      send_phase(1'b0, LEAD_MARK_HI - 16'd1);
      send_phase(1'b1, REP_SPACE_LO + 16'd1);
      send_phase(1'b0, SHORT_LO + 16'd1);
      // repeat space followed by a space instead of a mark
      send_phase(1'b0, 16'd2800);
      send_phase(1'b1, REP_SPACE_HI - 16'd1);
      send_phase(1'b1, 16'd170);
      // space where a bit mark belongs
      send_phase(1'b0, 16'd2800);
      send_phase(1'b1, LEAD_SPACE_LO + 16'd1);
      send_phase(1'b1, 16'd170);
      // bit space on the short upper bound
      send_phase(1'b0, 16'd2800);
      send_phase(1'b1, LEAD_SPACE_HI - 16'd1);
      send_phase(1'b0, SHORT_HI - 16'd1);
      send_phase(1'b1, SHORT_HI);
      // bit mark on the short lower bound
      send_phase(1'b0, 16'd2800);
      send_phase(1'b1, 16'd1400);
      send_phase(1'b0, SHORT_LO);
      // mark where a bit space belongs
      send_phase(1'b0, 16'd2800);
      send_phase(1'b1, 16'd1400);
      send_phase(1'b0, 16'd170);
      send_phase(1'b0, 16'd520);

      run_phase(0, 0, PHASE_ITEMS);
      // hold off the receiver while the sender keeps pushing
      hold_requests = hold_requests + 1;
      run_phase(0, 0, 80);
      run_phase(75, 0, PHASE_ITEMS);
      run_phase(0, 75, PHASE_ITEMS);
      run_phase(32, 32, PHASE_ITEMS);
      req_valid <= 1'b0;

      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule

// ----- nec_ir_pulse_decoder.f -----
+incdir+rtl
rtl/nirpd_pkg.sv
rtl/nirpd_classify.sv
rtl/nec_ir_pulse_decoder.sv
rtl/nirpd_checker.sv
test/tb_top.sv
